// File: rtl/decimal_literal_scanner_assert.svh
// assertion macros shared by the decimal literal scanner modules
`ifndef DECIMAL_LITERAL_SCANNER_ASSERT_SVH
`define DECIMAL_LITERAL_SCANNER_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define DLS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define DLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dls_pkg.sv
// shared types and constants of the decimal literal scanner
package dls_pkg;

    // longest literal that is counted before saturation
    localparam int MAX_LEN = 255;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // reported length width
    localparam int LEN_W = 8;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // character classes produced by the front
    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_SIGN,
        CC_POINT,
        CC_EMARK,
        CC_STOP
    } t_char_class;

    // one classified character moving between the parts
    typedef struct packed {
        logic        valid;
        t_char_class cls;
    } t_token;

endpackage

// File: rtl/dls_if.sv
// request channels for text characters and literal results
interface dls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       at_end;

    modport source (output valid, output ch, output at_end, input ready);
    modport sink   (input valid, input ch, input at_end, output ready);
endinterface

interface dls_out_if;
    logic                     valid;
    logic                     ready;
    logic [dls_pkg::LEN_W-1:0] literal_length;
    logic                     length_overflow;

    modport source (output valid, output literal_length, output length_overflow,
                    input ready);
    modport sink   (input valid, input literal_length, input length_overflow,
                    output ready);
endinterface

// File: rtl/dls_front.sv
// front part: accepts character requests and classifies them
module dls_front (
    dls_in_if.sink          i_in,
    input  logic            i_full,
    output dls_pkg::t_token o_push
);

    dls_pkg::t_char_class cls;

    // map the byte to its class, end marker terminates like any stray byte
    always_comb begin
        if (i_in.at_end) begin
            cls = dls_pkg::CC_STOP;
        end else if (i_in.ch >= 8'h30 && i_in.ch <= 8'h39) begin
            cls = dls_pkg::CC_DIGIT;
        end else if (i_in.ch == 8'h2b || i_in.ch == 8'h2d) begin
            cls = dls_pkg::CC_SIGN;
        end else if (i_in.ch == 8'h2e) begin
            cls = dls_pkg::CC_POINT;
        end else if (i_in.ch == 8'h65 || i_in.ch == 8'h45) begin
            cls = dls_pkg::CC_EMARK;
        end else begin
            cls = dls_pkg::CC_STOP;
        end
    end

    // accept whenever the queue has room
    assign i_in.ready   = !i_full;
    assign o_push.valid = i_in.valid && !i_full;
    assign o_push.cls   = cls;

endmodule

// File: rtl/dls_queue.sv
// short queue of classified characters between front and back
module dls_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dls_pkg::t_token i_push,
    input  logic            i_pop,
    output logic            o_full,
    output dls_pkg::t_token o_head
);

    `include "decimal_literal_scanner_assert.svh"

    localparam int PTR_W = $clog2(dls_pkg::Q_DEPTH);
    localparam int LVL_W = $clog2(dls_pkg::Q_DEPTH + 1);

    dls_pkg::t_char_class r_mem [dls_pkg::Q_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [LVL_W-1:0]     r_level;
    logic                 push;
    logic                 pop;

    assign push   = i_push.valid && !o_full;
    assign pop    = i_pop && (r_level != '0);
    assign o_full = (r_level == LVL_W'(dls_pkg::Q_DEPTH));

    // head entry
    assign o_head.valid = (r_level != '0);
    assign o_head.cls   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.cls;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(dls_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(dls_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (pop && !push) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    `DLS_ASSERT_ALWAYS(a_level_bound, r_level <= LVL_W'(dls_pkg::Q_DEPTH), "queue level past depth")
    `DLS_ASSERT_NEXT(a_level_up, push && !pop, r_level == $past(r_level) + LVL_W'(1), "level not raised")
    `DLS_ASSERT_NEXT(a_level_down, pop && !push, r_level == $past(r_level) - LVL_W'(1), "level not lowered")

endmodule

// File: rtl/dls_back.sv
// back part: literal scan state machine and result register
module dls_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dls_pkg::t_token i_head,
    output logic            o_pop,
    dls_out_if.source       o_out
);

    `include "decimal_literal_scanner_assert.svh"

    localparam int CNT_W  = dls_pkg::CNT_W;
    localparam int LEN_W  = dls_pkg::LEN_W;
    localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(dls_pkg::MAX_LEN);

    typedef enum logic [2:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_EXPMARK,
        PH_EXPSIGN,
        PH_EXPDIG
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_mant, n_mant;
    logic [CNT_W-1:0] r_mark_pos, n_mark_pos;
    logic             r_exp_dig, n_exp_dig;
    logic             r_sat, n_sat;
    logic             r_mark_sat, n_mark_sat;
    logic             r_out_valid, n_out_valid;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;

    logic             take;
    logic             fits;
    logic             dig, sign, point, emark;
    logic [CNT_W-1:0] res_cnt;
    logic             res_ovf;
    logic [WIDE_W-1:0] res_wide;

    // take a character when the result register can absorb a termination
    assign take  = i_head.valid && (!r_out_valid || o_out.ready);
    assign o_pop = take;

    assign dig   = (i_head.cls == dls_pkg::CC_DIGIT);
    assign sign  = (i_head.cls == dls_pkg::CC_SIGN);
    assign point = (i_head.cls == dls_pkg::CC_POINT);
    assign emark = (i_head.cls == dls_pkg::CC_EMARK);

    // does the character extend the literal
    always_comb begin
        fits       = 1'b0;
        n_phase    = r_phase;
        n_mant     = r_mant;
        n_mark_pos = r_mark_pos;
        n_mark_sat = r_mark_sat;
        n_exp_dig  = r_exp_dig;
        unique case (r_phase)
            PH_START, PH_INT: begin
                if (dig) begin
                    n_mant  = 1'b1;
                    n_phase = PH_INT;
                    fits    = 1'b1;
                end else if (sign && r_phase == PH_START) begin
                    n_phase = PH_INT;
                    fits    = 1'b1;
                end else if (point) begin
                    n_phase = PH_FRAC;
                    fits    = 1'b1;
                end else if (emark && r_mant) begin
                    n_mark_pos = r_count;
                    n_mark_sat = r_sat;
                    n_phase    = PH_EXPMARK;
                    fits       = 1'b1;
                end
            end
            PH_FRAC: begin
                if (dig) begin
                    n_mant = 1'b1;
                    fits   = 1'b1;
                end else if (emark && r_mant) begin
                    n_mark_pos = r_count;
                    n_mark_sat = r_sat;
                    n_phase    = PH_EXPMARK;
                    fits       = 1'b1;
                end
            end
            PH_EXPMARK: begin
                if (sign) begin
                    n_phase = PH_EXPSIGN;
                    fits    = 1'b1;
                end else if (dig) begin
                    n_exp_dig = 1'b1;
                    n_phase   = PH_EXPDIG;
                    fits      = 1'b1;
                end
            end
            PH_EXPSIGN, PH_EXPDIG: begin
                if (dig) begin
                    n_exp_dig = 1'b1;
                    n_phase   = PH_EXPDIG;
                    fits      = 1'b1;
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
    end

    // length at termination: zero without a mantissa digit, backing out a bare exponent mark or sign
    always_comb begin
        if (!r_mant) begin
            res_cnt = '0;
            res_ovf = 1'b0;
        end else if ((r_phase == PH_EXPMARK || r_phase == PH_EXPSIGN) && !r_exp_dig) begin
            res_cnt = r_mark_pos;
            res_ovf = r_mark_sat;
        end else begin
            res_cnt = r_count;
            res_ovf = r_sat;
        end
        res_wide = WIDE_W'(res_cnt);
    end

    // next values of count, saturation flag and result
    always_comb begin
        n_count     = r_count;
        n_sat       = r_sat;
        n_out_valid = r_out_valid && !o_out.ready;
        n_len       = r_len;
        n_ovf       = r_ovf;
        if (take && fits) begin
            if (r_count < CNT_MAX) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_sat = 1'b1;
            end
        end
    end

    // scan state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_count     <= '0;
            r_mant      <= 1'b0;
            r_mark_pos  <= '0;
            r_exp_dig   <= 1'b0;
            r_sat       <= 1'b0;
            r_mark_sat  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (take && !fits) begin
            r_phase     <= PH_START;
            r_count     <= '0;
            r_mant      <= 1'b0;
            r_mark_pos  <= '0;
            r_exp_dig   <= 1'b0;
            r_sat       <= 1'b0;
            r_mark_sat  <= 1'b0;
            r_out_valid <= 1'b1;
            r_len       <= res_wide[LEN_W-1:0];
            r_ovf       <= res_ovf;
        end else begin
            if (take) begin
                r_phase    <= n_phase;
                r_mant     <= n_mant;
                r_mark_pos <= n_mark_pos;
                r_exp_dig  <= n_exp_dig;
                r_mark_sat <= n_mark_sat;
                r_count    <= n_count;
                r_sat      <= n_sat;
            end
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.literal_length  = r_len;
    assign o_out.length_overflow = r_ovf;

    `DLS_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_MAX, "count past saturation limit")
    `DLS_ASSERT_ALWAYS(a_sat_at_max, !r_sat || r_count == CNT_MAX, "saturated below limit")
    `DLS_ASSERT_ALWAYS(a_mark_bound, r_mark_pos <= r_count, "exponent mark beyond count")

endmodule

// File: rtl/decimal_literal_scanner.sv
// decimal literal scanner: one character request per cycle, one length per terminating character
// throughput: one character per cycle, until a result waits unread and the queue fills
// result path: a terminating character is written into the queue, then the back part takes
//   it from the queue head and loads the result register once no earlier result waits unread
// reset: synchronous active low, empties the queue, clears the scan and drops the result
module decimal_literal_scanner (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dls_in_if.sink    i_in,
    dls_out_if.source o_out
);

    dls_pkg::t_token push;
    dls_pkg::t_token head;
    logic            full;
    logic            pop;

    // classify incoming characters
    dls_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push)
    );

    // decouple classification from the scan
    dls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // run the scan and hold the result
    dls_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
